// ===== design/dol_pkg.sv =====
// package for the driver override latch
// item, configuration and result types, codes and saturation helpers
// no dependencies
package dol_pkg;

	localparam int DOL_QUEUE_DEPTH = 2;
	localparam int IN_DATA_W = 120;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic [1:0] RSN_NONE = 2'd0;
	localparam logic [1:0] RSN_BOOT = 2'd1;
	localparam logic [1:0] RSN_BELOW = 2'd2;
	localparam logic [1:0] RSN_SERVO = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] CFG_FLAGS = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_STEER_THR = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_PEDAL_THR = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_RET = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SUSTAIN = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_RES_THR = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_BREAKAWAY = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_MOTION = 3'd7;

	localparam logic [14:0] STEER_THR_RST = 15'd3277;
	localparam logic [32:0] US_HALF = 33'd500000;
	// one million is 2^6 * 15625; divide by 15625 through a reciprocal
	localparam int US_SHIFT = 6;
	localparam logic [27:0] US_RECIP = 28'd140737489;
	localparam int RECIP_SHIFT = 41;
	localparam int DIV_BITS = 13;

	typedef struct packed {
		logic [3:0] flags;
		logic [14:0] steer_thr;
		logic [31:0] pedal_thr;
		logic [31:0] auto_ret;
		logic [31:0] sustain;
		logic [15:0] res_thr;
		logic [63:0] breakaway;
		logic [63:0] motion;
	} dol_cfg_t;

	typedef struct packed {
		logic op;
		logic resume;
		logic ovr;
		logic servo;
		logic steer_hit;
		logic pedal_hit;
		logic signed [17:0] actual;
		logic [16:0] absf;
		logic force_neg;
		logic [15:0] dt;
	} dol_item_t;

	typedef struct packed {
		logic [15:0] residual;
		logic [1:0] reason;
		logic returned;
		logic entered;
		logic long_manual;
		logic lat_man;
	} dol_result_t;

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		logic signed [15:0] r;
		if (v > 21'sd32767)
			r = 16'sh7fff;
		else if (v < -21'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[32] ? 32'hffff_ffff : s[31:0];
	endfunction

endpackage

// ===== design/driver_override_latch_top.sv =====
// top level of the driver override latch
// holds the configuration registers and joins front, queue and back
// depends on dol_pkg, dol_front, dol_fifo and dol_back
//
// usage
// input stream s_* carries one item per control frame or return request;
// tuser selects which, tdata holds the frame samples
// output stream m_* gives exactly one result item per input item
// configuration is written through cfg_we/cfg_addr/cfg_data while idle
// sequence: after the item is taken the back part goes straight to the result
// when it has no shadow work (request, override off, resume edge, servo off),
// computes the residual on a bootstrap frame, first checks for motion when the
// shadow wheel stays put, and also steps the wheel when it moves (two multiplies,
// a rounding add and a reciprocal divide by one million), plus a step for a
// partial reanchor; throughput: one item per back-part pass, set by the
// sequencer in the back part; a 2-entry queue in front keeps input open
// reset clears latches, timers, shadow state and configuration to defaults
// when m_tready is low the result waits in the output register, the back part
// waits with the next result and the queue fills before s_tready drops
module driver_override_latch_top import dol_pkg::*; #(
	parameter int QUEUE_DEPTH = DOL_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// steering, throttle, brake, resume_button, override_button, servo_active,
	// target_pos, pos_err, wheel_force, frame_time, zero fill
	input logic [IN_DATA_W-1:0] s_tdata,
	// operation
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// lateral_manual, longitudinal_manual, entered_manual, returned_auto,
	// latch_block_reason, residual, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input logic cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	dol_cfg_t cfg_q;
	dol_item_t push_item, head;
	dol_result_t result;
	logic push, full, pop, not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{flags: '0, steer_thr: STEER_THR_RST, pedal_thr: '0, auto_ret: '0,
				sustain: '0, res_thr: '0, breakaway: '0, motion: '0};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FLAGS: cfg_q.flags <= cfg_data[3:0];
				CFG_STEER_THR: cfg_q.steer_thr <= cfg_data[14:0];
				CFG_PEDAL_THR: cfg_q.pedal_thr <= cfg_data[31:0];
				CFG_AUTO_RET: cfg_q.auto_ret <= cfg_data[31:0];
				CFG_SUSTAIN: cfg_q.sustain <= cfg_data[31:0];
				CFG_RES_THR: cfg_q.res_thr <= cfg_data[15:0];
				CFG_BREAKAWAY: cfg_q.breakaway <= cfg_data;
				CFG_MOTION: cfg_q.motion <= cfg_data;
				default: ;
			endcase
		end
	end

	dol_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg(cfg_q),
		.q_full(full),
		.push(push),
		.item(push_item)
	);

	dol_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	dol_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(not_empty),
		.q_head(head),
		.q_pop(pop),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_result(result)
	);

	assign m_tdata = {2'b00, result.residual, result.reason, result.returned,
		result.entered, result.long_manual, result.lat_man};

	a_servo_no_residual: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:4] == RSN_SERVO) |-> (m_tdata[21:6] == '0))
		else $error("residual reported while servo path inactive");

	a_enter_return_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
		else $error("entered and returned in one item");

	a_enter_manual: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> (m_tdata[0] || m_tdata[1]))
		else $error("entered manual with no domain manual");

endmodule

// ===== design/dol_fifo.sv =====
// short item queue between the front and back parts
// depends on dol_pkg for the item type
module dol_fifo import dol_pkg::*; #(
	parameter int DEPTH = DOL_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dol_item_t push_item,
	output logic full,
	input logic pop,
	output logic not_empty,
	output dol_item_t head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dol_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/dol_front.sv =====
// front part: takes items off the input stream and classifies them
// depends on dol_pkg for the item and configuration types
module dol_front import dol_pkg::*; (
	input logic s_tvalid,
	output logic s_tready,
	input logic [IN_DATA_W-1:0] s_tdata,
	input logic s_tuser,
	input dol_cfg_t cfg,
	input logic q_full,
	output logic push,
	output dol_item_t item
);
	logic signed [15:0] steer, target, force_in;
	logic signed [16:0] perr;
	logic [14:0] throttle, brake;
	logic [16:0] steer_mag;

	assign steer = s_tdata[15:0];
	assign throttle = s_tdata[30:16];
	assign brake = s_tdata[45:31];
	assign target = s_tdata[64:49];
	assign perr = s_tdata[81:65];
	assign force_in = s_tdata[97:82];
	assign steer_mag = steer[15] ? 17'(-{steer[15], steer}) : {1'b0, steer};

	assign s_tready = !q_full;
	assign push = s_tvalid && !q_full;

	always_comb begin
		item.op = s_tuser;
		item.resume = s_tdata[46];
		item.ovr = s_tdata[47];
		item.servo = s_tdata[48];
		item.steer_hit = steer_mag > {2'b00, cfg.steer_thr};
		item.pedal_hit = ({1'b0, throttle} > cfg.pedal_thr[15:0]) ||
			({1'b0, brake} > cfg.pedal_thr[31:16]);
		item.actual = 18'(target) - 18'(perr);
		item.absf = force_in[15] ? 17'(-{force_in[15], force_in}) : {1'b0, force_in};
		item.force_neg = force_in[15];
		item.dt = s_tdata[113:98];
	end

endmodule

// ===== design/dol_back.sv =====
// back part: latch state, shadow wheel model and timers, one item at a time
// depends on dol_pkg for types, codes and saturation helpers
module dol_back import dol_pkg::*; (
	input logic clk,
	input logic arst_n,
	input dol_cfg_t cfg,
	input logic q_valid,
	input dol_item_t q_head,
	output logic q_pop,
	output logic m_valid,
	input logic m_ready,
	output dol_result_t m_result
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_A = 4'd1;
	localparam logic [3:0] ST_B = 4'd2;
	localparam logic [3:0] ST_C = 4'd3;
	localparam logic [3:0] ST_RND = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_POS = 4'd6;
	localparam logic [3:0] ST_RES = 4'd7;
	localparam logic [3:0] ST_RA = 4'd8;
	localparam logic [3:0] ST_FIN = 4'd9;

	logic [3:0] state_q;
	dol_item_t it_q;
	logic lat_mode_q, long_mode_q, resume_prev_q;
	logic [31:0] idle_q, sustain_q;
	logic hist_q, shv_q, moving_q;
	logic signed [15:0] shadow_q, anchor_q;
	logic lat_act_q, long_act_q, was_q, returned_q, normal_q, suppress_q, diff_neg_q;
	logic [1:0] reason_q;
	logic [15:0] res_q;
	logic [34:0] prod_q;
	logic [32:0] rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic out_valid_q;
	dol_result_t out_q;

	logic en, lat_cfg, long_cfg, btn_ok, lat0, long0, edge_a, out_free;
	logic signed [18:0] diff_anchor, diff_sh;
	logic [18:0] mag_anchor, mag_sh;
	logic seen, start, moving_n, below, lat_act_r, reanchor, timeout;
	logic [15:0] bottom, speed, res_v;
	logic signed [17:0] excess;
	logic [54:0] quo_prod;
	logic signed [20:0] pos_sum, ra_sum;
	logic [35:0] ra_round;
	logic [31:0] sus_t, idle_t;
	logic lm, gm;

	assign en = cfg.flags[0];
	assign lat_cfg = cfg.flags[1];
	assign long_cfg = cfg.flags[2];
	assign btn_ok = cfg.flags[3];
	assign lat0 = lat_cfg && lat_mode_q;
	assign long0 = long_cfg && long_mode_q;
	assign edge_a = it_q.resume && !resume_prev_q;
	assign out_free = !out_valid_q || m_ready;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign m_valid = out_valid_q;
	assign m_result = out_q;

	always_comb begin
		diff_anchor = 19'(it_q.actual) - 19'(anchor_q);
		mag_anchor = diff_anchor[18] ? 19'(-diff_anchor) : diff_anchor;
		seen = mag_anchor > {3'd0, cfg.motion[47:32]};
		bottom = it_q.force_neg ? cfg.breakaway[47:32] : cfg.breakaway[31:16];
		start = (it_q.absf >= {1'b0, cfg.breakaway[15:0]}) ||
			((it_q.absf >= {1'b0, bottom}) && seen);
		moving_n = moving_q || start;
		excess = 18'({1'b0, it_q.absf}) - 18'({2'b00, cfg.breakaway[63:48]});
		speed = (prod_q[32:12] > {5'd0, cfg.motion[31:16]}) ? cfg.motion[31:16] :
			prod_q[27:12];
		quo_prod = 55'(rem_q[32:US_SHIFT] * US_RECIP);
		pos_sum = it_q.force_neg ? 21'(shadow_q) + 21'({1'b0, quo_q}) :
			21'(shadow_q) - 21'({1'b0, quo_q});
		diff_sh = 19'(it_q.actual) - 19'(shadow_q);
		mag_sh = diff_sh[18] ? 19'(-diff_sh) : diff_sh;
		res_v = (mag_sh > 19'd65535) ? 16'hffff : mag_sh[15:0];
		below = res_v <= cfg.res_thr;
		sus_t = sat_add32(sustain_q, it_q.dt);
		lat_act_r = lat_act_q || (!suppress_q && !below && (sus_t >= cfg.sustain));
		reanchor = !suppress_q && !lat_act_r && !lat_mode_q && below;
		ra_round = {1'b0, prod_q} + 36'd32768;
		ra_sum = diff_neg_q ? 21'(shadow_q) - 21'(ra_round[35:16]) :
			21'(shadow_q) + 21'(ra_round[35:16]);
		lm = lat_mode_q || lat_act_q;
		gm = long_mode_q || long_act_q;
		idle_t = sat_add32(idle_q, it_q.dt);
		timeout = !(lat_act_q || long_act_q) && (lm || gm) && (cfg.auto_ret != '0) &&
			(idle_t >= cfg.auto_ret);
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			it_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lat_mode_q <= 1'b0;
			long_mode_q <= 1'b0;
			resume_prev_q <= 1'b0;
			idle_q <= '0;
			sustain_q <= '0;
			hist_q <= 1'b0;
			shv_q <= 1'b0;
			moving_q <= 1'b0;
			shadow_q <= '0;
			anchor_q <= '0;
			lat_act_q <= 1'b0;
			long_act_q <= 1'b0;
			was_q <= 1'b0;
			returned_q <= 1'b0;
			normal_q <= 1'b0;
			suppress_q <= 1'b0;
			diff_neg_q <= 1'b0;
			reason_q <= RSN_NONE;
			res_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (m_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_A;
				end
				ST_A: begin
					res_q <= '0;
					if (it_q.op == OP_REQUEST) begin
						reason_q <= RSN_NONE;
						normal_q <= 1'b0;
						returned_q <= lat_mode_q || long_mode_q;
						if (lat_cfg)
							lat_mode_q <= 1'b0;
						if (long_cfg)
							long_mode_q <= 1'b0;
						idle_q <= '0;
						state_q <= ST_FIN;
					end else if (!en) begin
						reason_q <= RSN_NONE;
						normal_q <= 1'b0;
						returned_q <= 1'b0;
						lat_mode_q <= lat_cfg;
						long_mode_q <= long_cfg;
						state_q <= ST_FIN;
					end else begin
						resume_prev_q <= it_q.resume;
						was_q <= lat0 || long0;
						if (edge_a) begin
							reason_q <= RSN_NONE;
							normal_q <= 1'b0;
							lat_mode_q <= 1'b0;
							long_mode_q <= 1'b0;
							returned_q <= lat0 || long0;
							idle_q <= '0;
							sustain_q <= '0;
							hist_q <= 1'b0;
							shv_q <= 1'b0;
							moving_q <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							normal_q <= 1'b1;
							lat_mode_q <= lat0;
							long_mode_q <= long0;
							lat_act_q <= lat_cfg && ((!it_q.servo && it_q.steer_hit) ||
								(btn_ok && it_q.ovr));
							long_act_q <= long_cfg && (it_q.pedal_hit || (btn_ok && it_q.ovr));
							if (lat_cfg && it_q.servo) begin
								suppress_q <= !hist_q || (it_q.dt == '0);
								hist_q <= 1'b1;
								if (!shv_q) begin
									shadow_q <= sat16(21'(it_q.actual));
									anchor_q <= sat16(21'(it_q.actual));
									moving_q <= 1'b0;
									shv_q <= 1'b1;
								end
								state_q <= (!hist_q || (it_q.dt == '0)) ? ST_RES : ST_B;
							end else begin
								sustain_q <= '0;
								hist_q <= 1'b0;
								shv_q <= 1'b0;
								moving_q <= 1'b0;
								reason_q <= RSN_SERVO;
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_B: begin
					if (!moving_n) begin
						state_q <= ST_RES;
					end else if (excess <= 18'sd0) begin
						moving_q <= 1'b0;
						anchor_q <= sat16(21'(it_q.actual));
						state_q <= ST_RES;
					end else begin
						moving_q <= 1'b1;
						prod_q <= 35'(cfg.motion[15:0] * excess[16:0]);
						state_q <= ST_C;
					end
				end
				ST_C: begin
					rem_q <= 33'(speed * it_q.dt);
					state_q <= ST_RND;
				end
				ST_RND: begin
					rem_q <= rem_q + US_HALF;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					quo_q <= quo_prod[RECIP_SHIFT +: DIV_BITS];
					state_q <= ST_POS;
				end
				ST_POS: begin
					shadow_q <= sat16(pos_sum);
					state_q <= ST_RES;
				end
				ST_RES: begin
					res_q <= res_v;
					reason_q <= suppress_q ? RSN_BOOT : (below ? RSN_BELOW : RSN_NONE);
					sustain_q <= (suppress_q || below) ? '0 : sus_t;
					lat_act_q <= lat_act_r;
					diff_neg_q <= diff_sh[18];
					prod_q <= 35'(mag_sh * cfg.motion[63:48]);
					if (reanchor && (cfg.motion[63:48] != '0))
						state_q <= ST_RA;
					else
						state_q <= ST_FIN;
					if (reanchor && (cfg.motion[63:48] == '0))
						shadow_q <= sat16(21'(it_q.actual));
				end
				ST_RA: begin
					shadow_q <= sat16(ra_sum);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.residual <= res_q;
						out_q.reason <= reason_q;
						state_q <= ST_IDLE;
						if (normal_q) begin
							out_q.entered <= !was_q && (lm || gm);
							if (lat_act_q || long_act_q) begin
								idle_q <= '0;
							end else if ((lm || gm) && (cfg.auto_ret != '0)) begin
								idle_q <= timeout ? '0 : idle_t;
							end
							if (timeout) begin
								lat_mode_q <= lat_cfg ? 1'b0 : lm;
								long_mode_q <= long_cfg ? 1'b0 : gm;
								out_q.lat_man <= lat_cfg ? 1'b0 : lm;
								out_q.long_manual <= long_cfg ? 1'b0 : gm;
							end else begin
								lat_mode_q <= lm;
								long_mode_q <= gm;
								out_q.lat_man <= lm;
								out_q.long_manual <= gm;
							end
							out_q.returned <= timeout && was_q;
						end else begin
							out_q.entered <= 1'b0;
							out_q.returned <= returned_q;
							out_q.lat_man <= lat_mode_q;
							out_q.long_manual <= long_mode_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sim/driver_override_latch_top_test.sv =====
// self-checking test of the driver override latch top level
// predicts every result from a local model of the latches and shadow wheel
// depends on dol_pkg and driver_override_latch_top
module driver_override_latch_top_test;
	import dol_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic op;
		logic signed [15:0] steer;
		logic [14:0] thr;
		logic [14:0] brk;
		logic resume;
		logic ovr;
		logic servo;
		logic signed [15:0] target;
		logic signed [16:0] perr;
		logic signed [15:0] force_in;
		logic [15:0] dt;
	} frame_t;

	typedef struct packed {
		logic [15:0] residual;
		logic [1:0] reason;
		logic returned;
		logic entered;
		logic long_m;
		logic lat_m;
	} mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of configuration and state
	logic [3:0] p_flags;
	logic [14:0] p_steer_thr;
	logic [31:0] p_pedal_thr, p_auto_ret, p_sustain;
	logic [15:0] p_res_thr;
	logic [63:0] p_brk, p_motion;
	logic lat_mode, long_mode, resume_prev, hist_valid, shd_valid, shd_moving;
	longint idle_t, sustain_acc, shd_pos, rest_anchor;

	mode_t expected_modes[$];
	int errors = 0;
	int idle_pct = 37;
	int stall_pct = 37;
	int quiet_cycles = 0;

	driver_override_latch_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint add_sat32(longint a, longint b);
		return (a + b > 64'hffff_ffff) ? 64'hffff_ffff : a + b;
	endfunction

	function automatic longint f16(logic [63:0] r, int k);
		return longint'(r[16*k +: 16]);
	endfunction

	function automatic mode_t predict_modes(frame_t f);
		mode_t r;
		bit en, lat_cfg, long_cfg, btn_ok, was, edge_hit, lat_act, long_act;
		bit suppress, below, seen;
		longint actual, absf, res, stp, bottom, excess, speed, g, diff, d, dt;
		r = '0;
		en = p_flags[0];
		lat_cfg = p_flags[1];
		long_cfg = p_flags[2];
		btn_ok = p_flags[3];
		dt = longint'(f.dt);
		if (f.op == OP_REQUEST) begin
			was = lat_mode || long_mode;
			if (lat_cfg) lat_mode = 0;
			if (long_cfg) long_mode = 0;
			idle_t = 0;
			r.returned = was;
		end else begin
			if (!lat_cfg) lat_mode = 0;
			if (!long_cfg) long_mode = 0;
			if (!en) begin
				if (lat_cfg) lat_mode = 1;
				if (long_cfg) long_mode = 1;
			end else begin
				was = lat_mode || long_mode;
				edge_hit = f.resume && !resume_prev;
				resume_prev = f.resume;
				if (edge_hit) begin
					if (lat_cfg) lat_mode = 0;
					if (long_cfg) long_mode = 0;
					idle_t = 0;
					sustain_acc = 0;
					hist_valid = 0;
					shd_valid = 0;
					shd_moving = 0;
					r.returned = was;
				end else begin
					lat_act = 0;
					long_act = 0;
					if (lat_cfg && !f.servo)
						lat_act = absv(longint'(f.steer)) > longint'(p_steer_thr);
					if (long_cfg)
						long_act = (f.thr > p_pedal_thr[15:0]) || (f.brk > p_pedal_thr[31:16]);
					if (btn_ok && f.ovr) begin
						if (lat_cfg) lat_act = 1;
						if (long_cfg) long_act = 1;
					end
					if (lat_cfg && f.servo) begin
						suppress = !hist_valid || dt == 0;
						actual = longint'(f.target) - longint'(f.perr);
						absf = absv(longint'(f.force_in));
						hist_valid = 1;
						if (!shd_valid) begin
							shd_pos = clamp16(actual);
							rest_anchor = clamp16(actual);
							shd_moving = 0;
							shd_valid = 1;
						end
						if (!suppress) begin
							stp = 0;
							if (!shd_moving) begin
								bottom = f16(p_brk, f.force_in >= 0 ? 1 : 2);
								seen = absv(actual - rest_anchor) > f16(p_motion, 2);
								if (absf >= f16(p_brk, 0) || (absf >= bottom && seen))
									shd_moving = 1;
							end
							if (shd_moving) begin
								excess = absf - f16(p_brk, 3);
								if (excess <= 0) begin
									shd_moving = 0;
									rest_anchor = clamp16(actual);
								end else begin
									speed = (f16(p_motion, 0) * excess) >>> 12;
									if (speed > f16(p_motion, 1)) speed = f16(p_motion, 1);
									stp = (speed * dt + 500000) / 1000000;
									if (f.force_in >= 0) stp = -stp;
								end
							end
							shd_pos = clamp16(shd_pos + stp);
						end
						res = absv(actual - shd_pos);
						if (res > 65535) res = 65535;
						below = res <= longint'(p_res_thr);
						if (suppress || below) sustain_acc = 0;
						else begin
							sustain_acc = add_sat32(sustain_acc, dt);
							if (sustain_acc >= longint'(p_sustain)) lat_act = 1;
						end
						if (!suppress && !lat_act && !lat_mode && below) begin
							g = f16(p_motion, 3);
							if (g == 0) shd_pos = clamp16(actual);
							else begin
								diff = actual - shd_pos;
								d = (absv(diff) * g + 32768) >>> 16;
								if (diff < 0) d = -d;
								shd_pos = clamp16(shd_pos + d);
							end
						end
						r.reason = suppress ? RSN_BOOT : (below ? RSN_BELOW : RSN_NONE);
						r.residual = res[15:0];
					end else begin
						sustain_acc = 0;
						hist_valid = 0;
						shd_valid = 0;
						shd_moving = 0;
						r.reason = RSN_SERVO;
					end
					if (lat_act) lat_mode = 1;
					if (long_act) long_mode = 1;
					if (!was && (lat_mode || long_mode)) r.entered = 1;
					if (lat_act || long_act) idle_t = 0;
					else if ((lat_mode || long_mode) && p_auto_ret > 0) begin
						idle_t = add_sat32(idle_t, dt);
						if (idle_t >= longint'(p_auto_ret)) begin
							if (lat_cfg) lat_mode = 0;
							if (long_cfg) long_mode = 0;
							idle_t = 0;
							if (was) r.returned = 1;
						end
					end
				end
			end
		end
		r.lat_m = lat_mode;
		r.long_m = long_mode;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (s_tvalid && s_tready || m_tvalid && m_tready) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		mode_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[21:0];
			if (expected_modes.size() == 0) report_mismatch("unexpected item", 1, 0);
			else begin
				want = expected_modes.pop_front();
				if (got.lat_m !== want.lat_m) report_mismatch("lateral_manual", got.lat_m, want.lat_m);
				if (got.long_m !== want.long_m)
					report_mismatch("longitudinal_manual", got.long_m, want.long_m);
				if (got.entered !== want.entered)
					report_mismatch("entered_manual", got.entered, want.entered);
				if (got.returned !== want.returned)
					report_mismatch("returned_auto", got.returned, want.returned);
				if (got.reason !== want.reason) report_mismatch("reason", got.reason, want.reason);
				if (got.residual !== want.residual)
					report_mismatch("residual", got.residual, want.residual);
			end
		end
	end

	initial begin
		wait (quiet_cycles >= 20000);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_frame(frame_t f);
		cfg_we <= 1'b0;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f.op;
		s_tdata <= {6'd0, f.dt, f.force_in, f.perr, f.target, f.servo, f.ovr, f.resume,
			f.brk, f.thr, f.steer};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_modes.push_back(predict_modes(f));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		cfg_we <= 1'b0;
		while (expected_modes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] v);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_FLAGS: p_flags = v[3:0];
			CFG_STEER_THR: p_steer_thr = v[14:0];
			CFG_PEDAL_THR: p_pedal_thr = v[31:0];
			CFG_AUTO_RET: p_auto_ret = v[31:0];
			CFG_SUSTAIN: p_sustain = v[31:0];
			CFG_RES_THR: p_res_thr = v[15:0];
			CFG_BREAKAWAY: p_brk = v;
			default: p_motion = v;
		endcase
	endtask

	function automatic frame_t random_frame(bit servo_bias);
		frame_t f;
		f.op = ($urandom_range(99) < 4) ? OP_REQUEST : OP_FRAME;
		f.steer = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(6000) - 3000);
		f.thr = 15'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3000));
		f.brk = 15'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3000));
		f.resume = ($urandom_range(9) == 0);
		f.ovr = ($urandom_range(19) == 0);
		f.servo = servo_bias ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
		f.target = 16'(($urandom_range(7) == 0) ? $urandom : $urandom_range(4000) - 2000);
		f.perr = 17'(($urandom_range(7) == 0) ? $urandom : $urandom_range(2000) - 1000);
		f.force_in = 16'($urandom);
		f.dt = 16'(($urandom_range(15) == 0) ? $urandom :
			(($urandom_range(15) == 0) ? 0 : 1000));
		return f;
	endfunction

	task automatic test_directed;
		frame_t f;
		f = '{OP_FRAME, 16'sh8000, 15'h7fff, 15'h7fff, 1'b0, 1'b1, 1'b0, 16'sd0, 17'sd0,
			16'sd0, 16'd1000};
		send_frame(f);
		drain();
		write_reg(CFG_FLAGS, 64'hf);
		write_reg(CFG_PEDAL_THR, 64'h0100_0100);
		write_reg(CFG_AUTO_RET, 64'd3000);
		send_frame(f);
		f.steer = 16'sh7fff; f.ovr = 1'b0; f.thr = 15'd0; f.brk = 15'd0;
		send_frame(f);
		f.resume = 1'b1; send_frame(f);
		f.resume = 1'b0; f.steer = 16'sd0;
		repeat (4) send_frame(f);
		f.op = OP_REQUEST; send_frame(f);
		f.op = OP_FRAME; f.servo = 1'b1; f.target = 16'sh7fff; f.perr = -17'sd65536;
		f.force_in = 16'sh8000; send_frame(f);
		f.dt = 16'd0; send_frame(f);
		f.dt = 16'hffff; f.target = 16'sh8000; f.perr = 17'sd65535; f.force_in = 16'sh7fff;
		repeat (3) send_frame(f);
		f.servo = 1'b0; f.steer = 16'sh8000; send_frame(f);
		drain();
	endtask

	task automatic random_phase(int n, bit servo_bias);
		repeat (n) send_frame(random_frame(servo_bias));
	endtask

	task automatic test_shadow_settings;
		write_reg(CFG_FLAGS, 64'hb);
		write_reg(CFG_STEER_THR, 64'd0);
		write_reg(CFG_SUSTAIN, 64'd2500);
		write_reg(CFG_RES_THR, 64'd300);
		write_reg(CFG_BREAKAWAY, {16'd2000, 16'd6000, 16'd5000, 16'd12000});
		write_reg(CFG_MOTION, {16'd20000, 16'd200, 16'd8000, 16'd4000});
		random_phase(400, 1'b1);
		drain();
		write_reg(CFG_MOTION, {16'd0, 16'd100, 16'hffff, 16'hffff});
		write_reg(CFG_RES_THR, 64'hffff);
		write_reg(CFG_SUSTAIN, 64'd0);
		random_phase(150, 1'b1);
		drain();
	endtask

	task automatic test_random_settings;
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_FLAGS, 64'($urandom));
			write_reg(CFG_STEER_THR, (p == 0) ? 64'h7fff : 64'($urandom_range(3000)));
			write_reg(CFG_PEDAL_THR, (p == 1) ? 64'hffff_ffff :
				64'($urandom_range(3000) << 16 | $urandom_range(3000)));
			write_reg(CFG_AUTO_RET, (p == 2) ? 64'hffff_ffff : 64'($urandom_range(8000)));
			write_reg(CFG_SUSTAIN, (p == 3) ? 64'hffff_ffff : 64'($urandom_range(5000)));
			write_reg(CFG_RES_THR, 64'($urandom_range(2000)));
			write_reg(CFG_BREAKAWAY, {$urandom, $urandom});
			write_reg(CFG_MOTION, {$urandom, $urandom});
			if (p == 4) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = 37;
				stall_pct = 37;
			end
			random_phase(148, 1'b1);
			drain();
		end
	endtask

	initial begin
		p_flags = 0; p_steer_thr = 3277; p_pedal_thr = 0; p_auto_ret = 0; p_sustain = 0;
		p_res_thr = 0; p_brk = 0; p_motion = 0;
		lat_mode = 0; long_mode = 0; resume_prev = 0; hist_valid = 0; shd_valid = 0;
		shd_moving = 0; idle_t = 0; sustain_acc = 0; shd_pos = 0; rest_anchor = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_shadow_settings();
		test_random_settings();
		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
